>>> hdl/assert_macros.svh
// Assertion helpers, clocked on the rising edge with an active-low disable.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

>>> hdl/sbdn_pkg.sv
package sbdn_pkg;

    localparam int JOINT_COUNT  = 20;
    localparam int JOINT_BITS   = 5;
    localparam int COORD_BITS   = 15;
    localparam int FRAC_BITS    = 14;
    localparam int UNIT_BITS    = 16;

    localparam int STORE_BITS   = 3 * COORD_BITS;
    localparam int D_BITS       = COORD_BITS + 1;
    localparam int SQ_BITS      = 2 * COORD_BITS;
    localparam int S_BITS       = 2 * COORD_BITS + 2;
    localparam int Q_BITS       = FRAC_BITS + 1;
    localparam int R_BITS       = SQ_BITS + 2 * FRAC_BITS;
    localparam int ACC_BITS     = 2 * FRAC_BITS + 2 + S_BITS;
    localparam int BIT_CNT_BITS = $clog2(FRAC_BITS + 1);

    localparam int IN_PAY_BITS    = JOINT_BITS + 3 * COORD_BITS;
    localparam int IN_TDATA_BITS  = ((IN_PAY_BITS + 7) / 8) * 8;
    localparam int OUT_PAY_BITS   = JOINT_BITS + 3 * UNIT_BITS;
    localparam int OUT_TDATA_BITS = ((OUT_PAY_BITS + 7) / 8) * 8;

    localparam logic [UNIT_BITS-1:0] UNIT_MAX = {1'b0, {(UNIT_BITS-1){1'b1}}};

    typedef enum logic [9:0] {
        ST_IDLE      = 10'b00_0000_0001,
        ST_RD_CHILD  = 10'b00_0000_0010,
        ST_RD_PARENT = 10'b00_0000_0100,
        ST_DIFF      = 10'b00_0000_1000,
        ST_SQUARE    = 10'b00_0001_0000,
        ST_CHECK     = 10'b00_0010_0000,
        ST_INIT      = 10'b00_0100_0000,
        ST_BIT_A     = 10'b00_1000_0000,
        ST_BIT_B     = 10'b01_0000_0000,
        ST_EMIT      = 10'b10_0000_0000
    } state_t;

    function automatic logic [JOINT_BITS-1:0] bone_parent(input logic [JOINT_BITS-1:0] j);
        logic [JOINT_BITS-1:0] p;
        unique case (j)
            5'd2:  p = 5'd1;
            5'd3:  p = 5'd2;
            5'd4:  p = 5'd2;
            5'd5:  p = 5'd4;
            5'd6:  p = 5'd5;
            5'd7:  p = 5'd6;
            5'd8:  p = 5'd2;
            5'd9:  p = 5'd8;
            5'd10: p = 5'd9;
            5'd11: p = 5'd10;
            5'd13: p = 5'd12;
            5'd14: p = 5'd13;
            5'd15: p = 5'd14;
            5'd17: p = 5'd16;
            5'd18: p = 5'd17;
            5'd19: p = 5'd18;
            default: p = 5'd0;
        endcase
        return p;
    endfunction

    function automatic logic [COORD_BITS-1:0] mag_of(input logic signed [D_BITS-1:0] d);
        logic [D_BITS-1:0] a;
        a = d[D_BITS-1] ? D_BITS'(-d) : D_BITS'(d);
        return a[COORD_BITS-1:0];
    endfunction

    function automatic logic [UNIT_BITS-1:0] sat_unit(input logic [Q_BITS-1:0] q);
        logic [Q_BITS+UNIT_BITS-1:0] qe;
        qe = {{UNIT_BITS{1'b0}}, q};
        if (qe > (Q_BITS + UNIT_BITS)'(UNIT_MAX))
            return UNIT_MAX;
        return qe[UNIT_BITS-1:0];
    endfunction

endpackage

>>> hdl/sbdn_ram.sv
module sbdn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hdl/skeleton_bone_direction_normalizer_unit.sv
// Skeleton bone direction normalizer. Each transfer on the slave side writes one joint
// position into a 20-entry joint store (indexes 20 and up write nothing); a transfer with
// tlast set writes and then starts a frame that emits 20 results, joint 0 to 19, each the
// Q1.14 unit vector from the joint's parent, truncated toward zero. Hip centre gives zero;
// a joint equal to its parent gives zero with tuser set. The slave side is ready only while
// no frame is running. Joint 0 is emitted without reading the store, and a joint that sits
// on its parent skips the root search. For every other joint the time is set by the
// bit-serial root search, which runs a wide add (ST_BIT_A) and a compare (ST_BIT_B)
// on each of the FRAC_BITS + 1 result bits of every component.
// Results wait in an output register; a full register stalls the sequencer.
module skeleton_bone_direction_normalizer_unit
    import sbdn_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [IN_TDATA_BITS-1:0]  s_tdata,   // joint_index, pos_x, pos_y, pos_z
    input  logic                      s_tlast,   // frame_end
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [OUT_TDATA_BITS-1:0] m_tdata,   // out_joint, unit_x, unit_y, unit_z
    output logic                      m_tuser,   // degenerate
    output logic                      m_tlast    // last
);

`include "assert_macros.svh"

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    logic [JOINT_BITS-1:0]     joint_reg, joint_next;
    logic [1:0]                comp_reg, comp_next;
    logic [BIT_CNT_BITS-1:0]   bit_reg, bit_next;
    logic [STORE_BITS-1:0]     child_reg, child_next;
    logic signed [D_BITS-1:0]  d_reg [3];
    logic signed [D_BITS-1:0]  d_next [3];
    logic [SQ_BITS-1:0]        dsq_reg [3];
    logic [SQ_BITS-1:0]        dsq_next [3];
    logic [S_BITS-1:0]         s_reg, s_next;
    logic [R_BITS-1:0]         r_reg, r_next;
    logic [ACC_BITS-1:0]       q2s_reg, q2s_next;
    logic [ACC_BITS-1:0]       qs_reg, qs_next;
    logic [ACC_BITS-1:0]       acc_reg, acc_next;
    logic [Q_BITS-1:0]         q_reg, q_next;
    logic [UNIT_BITS-1:0]      unit_reg [3];
    logic [UNIT_BITS-1:0]      unit_next [3];
    logic                      degen_reg, degen_next;
    logic [OUT_PAY_BITS-1:0]   out_data_reg, out_data_next;
    logic                      out_degen_reg, out_degen_next;
    logic                      out_last_reg, out_last_next;

    logic                      s_accept;
    logic                      ram_we;
    logic [JOINT_BITS-1:0]     ram_raddr;
    logic [STORE_BITS-1:0]     ram_rdata;
    logic [COORD_BITS-1:0]     mag_cur;
    logic [SQ_BITS-1:0]        sq_cur;
    logic [ACC_BITS-1:0]       cand;
    logic [UNIT_BITS-1:0]      mag_unit;
    logic                      out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign ram_we   = s_accept && (s_tdata[JOINT_BITS-1:0] < JOINT_BITS'(JOINT_COUNT));
    assign ram_raddr = (state_reg == ST_RD_PARENT) ? bone_parent(joint_reg) : joint_reg;

    sbdn_ram #(
        .WIDTH (STORE_BITS),
        .DEPTH (JOINT_COUNT)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (s_tdata[JOINT_BITS-1:0]),
        .wdata (s_tdata[IN_PAY_BITS-1:JOINT_BITS]),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign mag_cur = mag_of(d_reg[comp_reg]);
    assign sq_cur  = SQ_BITS'(mag_cur) * SQ_BITS'(mag_cur);
    assign cand    = acc_reg + (ACC_BITS'(s_reg) << {bit_reg, 1'b0});
    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_tready;
        joint_next     = joint_reg;
        comp_next      = comp_reg;
        bit_next       = bit_reg;
        child_next     = child_reg;
        d_next         = d_reg;
        dsq_next       = dsq_reg;
        s_next         = s_reg;
        r_next         = r_reg;
        q2s_next       = q2s_reg;
        qs_next        = qs_reg;
        acc_next       = acc_reg;
        q_next         = q_reg;
        unit_next      = unit_reg;
        degen_next     = degen_reg;
        out_data_next  = out_data_reg;
        out_degen_next = out_degen_reg;
        out_last_next  = out_last_reg;
        mag_unit       = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_accept && s_tlast)
                begin
                    joint_next = '0;
                    unit_next  = '{default: '0};
                    degen_next = 1'b0;
                    state_next = ST_EMIT;
                end
            end
            ST_RD_CHILD:
            begin
                state_next = ST_RD_PARENT;
            end
            ST_RD_PARENT:
            begin
                child_next = ram_rdata;
                state_next = ST_DIFF;
            end
            ST_DIFF:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    d_next[k] = $signed({child_reg[k*COORD_BITS+COORD_BITS-1],
                                         child_reg[k*COORD_BITS +: COORD_BITS]})
                              - $signed({ram_rdata[k*COORD_BITS+COORD_BITS-1],
                                         ram_rdata[k*COORD_BITS +: COORD_BITS]});
                end
                s_next     = '0;
                comp_next  = '0;
                state_next = ST_SQUARE;
            end
            ST_SQUARE:
            begin
                dsq_next[comp_reg] = sq_cur;
                s_next = s_reg + S_BITS'(sq_cur);
                if (comp_reg == 2'd2)
                begin
                    comp_next  = '0;
                    state_next = ST_CHECK;
                end
                else
                begin
                    comp_next = comp_reg + 2'd1;
                end
            end
            ST_CHECK:
            begin
                if (s_reg == '0)
                begin
                    degen_next = 1'b1;
                    unit_next  = '{default: '0};
                    state_next = ST_EMIT;
                end
                else
                begin
                    degen_next = 1'b0;
                    state_next = ST_INIT;
                end
            end
            ST_INIT:
            begin
                r_next     = R_BITS'(dsq_reg[comp_reg]) << (2 * FRAC_BITS);
                q2s_next   = '0;
                qs_next    = '0;
                q_next     = '0;
                bit_next   = BIT_CNT_BITS'(FRAC_BITS);
                state_next = ST_BIT_A;
            end
            ST_BIT_A:
            begin
                acc_next   = q2s_reg + ((qs_reg << bit_reg) << 1);
                state_next = ST_BIT_B;
            end
            ST_BIT_B:
            begin
                // trial bit kept when (q + 2^b)^2 * s still fits under d^2 * 2^(2F)
                if (cand <= ACC_BITS'(r_reg))
                begin
                    q2s_next = cand;
                    qs_next  = qs_reg + (ACC_BITS'(s_reg) << bit_reg);
                    q_next   = q_reg | (Q_BITS'(1) << bit_reg);
                end
                if (bit_reg == '0)
                begin
                    mag_unit = sat_unit(q_next);
                    unit_next[comp_reg] = d_reg[comp_reg][D_BITS-1] ?
                                          UNIT_BITS'(-mag_unit) : mag_unit;
                    if (comp_reg == 2'd2)
                    begin
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        comp_next  = comp_reg + 2'd1;
                        state_next = ST_INIT;
                    end
                end
                else
                begin
                    bit_next   = bit_reg - BIT_CNT_BITS'(1);
                    state_next = ST_BIT_A;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {unit_reg[2], unit_reg[1], unit_reg[0], joint_reg};
                    out_degen_next = degen_reg;
                    out_last_next  = (joint_reg == JOINT_BITS'(JOINT_COUNT - 1));
                    if (joint_reg == JOINT_BITS'(JOINT_COUNT - 1))
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        joint_next = joint_reg + JOINT_BITS'(1);
                        state_next = ST_RD_CHILD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        joint_reg     <= joint_next;
        comp_reg      <= comp_next;
        bit_reg       <= bit_next;
        child_reg     <= child_next;
        d_reg         <= d_next;
        dsq_reg       <= dsq_next;
        s_reg         <= s_next;
        r_reg         <= r_next;
        q2s_reg       <= q2s_next;
        qs_reg        <= qs_next;
        acc_reg       <= acc_next;
        q_reg         <= q_next;
        unit_reg      <= unit_next;
        degen_reg     <= degen_next;
        out_data_reg  <= out_data_next;
        out_degen_reg <= out_degen_next;
        out_last_reg  <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TDATA_BITS'(out_data_reg);
    assign m_tuser  = out_degen_reg;
    assign m_tlast  = out_last_reg;

    `ASSERT_NEXT(a_frame_start, clk, rst_n, s_tvalid && s_tready && s_tlast, state_reg == ST_EMIT)
    `ASSERT_IMPLY(a_last_joint, clk, rst_n, m_tvalid && m_tlast, m_tdata[JOINT_BITS-1:0] == JOINT_BITS'(JOINT_COUNT - 1))
    `ASSERT_IMPLY(a_degen_zero, clk, rst_n, m_tvalid && m_tuser, m_tdata[OUT_PAY_BITS-1:JOINT_BITS] == '0)
    `ASSERT_IMPLY(a_bit_range, clk, rst_n, state_reg == ST_BIT_B, bit_reg <= BIT_CNT_BITS'(FRAC_BITS))

endmodule
